/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// an implication checked in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// an implication checked in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/nmeafc_pkg.sv */
`default_nettype none

package nmeafc_pkg;

    // ascii codes that steer the framer
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_B_UP   = 8'h42;
    localparam logic [7:0] CH_D_UP   = 8'h44;
    localparam logic [7:0] CH_G_UP   = 8'h47;
    localparam logic [7:0] CH_L_UP   = 8'h4C;
    localparam logic [7:0] CH_P_UP   = 8'h50;
    localparam logic [7:0] CH_S_UP   = 8'h53;
    localparam logic [7:0] CH_V_UP   = 8'h56;

    // counter limits
    localparam logic [4:0] COMMA_MAX     = 5'd31;
    localparam logic [2:0] FIELD_LEN_MAX = 3'd7;
    localparam logic [2:0] ID_LEN        = 3'd5;
    localparam logic [2:0] TALKER_LEN    = 3'd2;
    localparam logic [1:0] HEX_DIGITS    = 2'd2;
    localparam logic [1:0] AFTER_MAX     = 2'd3;

    typedef enum logic [2:0] {
        ST_OK_NO_CHECKSUM = 3'd0,
        ST_MATCH          = 3'd1,
        ST_MISMATCH       = 3'd2,
        ST_STAR_MISPLACED = 3'd3,
        ST_BAD_HEX        = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        TK_GP    = 3'd0,
        TK_GL    = 3'd1,
        TK_GB_BD = 3'd2,
        TK_GA    = 3'd3,
        TK_OTHER = 3'd4
    } talker_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_GSV   = 2'd2
    } kind_t;

    // one sentence report
    typedef struct packed {
        status_t     status;
        logic [7:0]  computed_checksum;
        logic [7:0]  received_checksum;
        logic [6:0]  sentence_length;
        logic [4:0]  field_count;
        logic        id_length_ok;
        talker_t     talker_code;
        kind_t       sentence_type;
    } report_t;

    // true for 0-9, A-F, a-f
    function automatic logic is_hex(input logic [7:0] c);
        logic ok;
        case (c) inside
            [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: ok = 1'b1;
            default:                                      ok = 1'b0;
        endcase
        return ok;
    endfunction

    // nibble value of a hex digit
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        case (c) inside
            [8'h30:8'h39]: n = c[3:0];
            default:       n = c[3:0] + 4'd9;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* src/nmeafc_core.sv */
`default_nettype none

module nmeafc_core #(
    parameter int LEN_CAP = 127
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           byte_in,
    output logic                      report_valid,
    output nmeafc_pkg::report_t       report
);

    localparam logic [6:0] LEN_CAP_W = 7'(LEN_CAP);

    logic       in_sentence_reg,      in_sentence_next;
    logic [7:0] held_byte_reg,        held_byte_next;
    logic       held_valid_reg,       held_valid_next;
    logic [7:0] running_xor_reg,      running_xor_next;
    logic       star_seen_reg,        star_seen_next;
    logic [1:0] after_star_count_reg, after_star_count_next;
    logic [7:0] hex_value_reg,        hex_value_next;
    logic       hex_error_reg,        hex_error_next;
    logic [6:0] length_count_reg,     length_count_next;
    logic [4:0] comma_count_reg,      comma_count_next;
    logic       first_field_done_reg, first_field_done_next;
    logic [2:0] first_field_len_reg,  first_field_len_next;
    logic [7:0] id_chars_reg [5];
    logic [7:0] id_chars_next [5];

    logic       clear_sentence;
    logic [7:0] c;

    assign c = held_byte_reg;

    // per-byte state update
    always_comb
    begin
        in_sentence_next      = in_sentence_reg;
        held_byte_next        = held_byte_reg;
        held_valid_next       = held_valid_reg;
        running_xor_next      = running_xor_reg;
        star_seen_next        = star_seen_reg;
        after_star_count_next = after_star_count_reg;
        hex_value_next        = hex_value_reg;
        hex_error_next        = hex_error_reg;
        length_count_next     = length_count_reg;
        comma_count_next      = comma_count_reg;
        first_field_done_next = first_field_done_reg;
        first_field_len_next  = first_field_len_reg;
        id_chars_next         = id_chars_reg;
        clear_sentence        = 1'b0;
        report_valid          = 1'b0;

        if (step)
        begin
            if (!in_sentence_reg)
            begin
                // hunting for the start of a sentence
                if (byte_in == nmeafc_pkg::CH_DOLLAR)
                begin
                    clear_sentence   = 1'b1;
                    in_sentence_next = 1'b1;
                end
            end
            else if (byte_in != nmeafc_pkg::CH_LF)
            begin
                // process the held byte, then hold the new one
                if (held_valid_reg)
                begin
                    if (length_count_reg < LEN_CAP_W)
                    begin
                        length_count_next = length_count_reg + 7'd1;
                    end
                    if (!star_seen_reg)
                    begin
                        if (c == nmeafc_pkg::CH_STAR)
                        begin
                            star_seen_next = 1'b1;
                        end
                        else
                        begin
                            running_xor_next = running_xor_reg ^ c;
                            if (c == nmeafc_pkg::CH_COMMA)
                            begin
                                if (comma_count_reg < nmeafc_pkg::COMMA_MAX)
                                begin
                                    comma_count_next = comma_count_reg + 5'd1;
                                end
                                first_field_done_next = 1'b1;
                            end
                            else if (!first_field_done_reg)
                            begin
                                if (first_field_len_reg < nmeafc_pkg::ID_LEN)
                                begin
                                    id_chars_next[first_field_len_reg] = c;
                                end
                                if (first_field_len_reg < nmeafc_pkg::FIELD_LEN_MAX)
                                begin
                                    first_field_len_next = first_field_len_reg + 3'd1;
                                end
                            end
                        end
                    end
                    else if (after_star_count_reg < nmeafc_pkg::AFTER_MAX)
                    begin
                        after_star_count_next = after_star_count_reg + 2'd1;
                        if (after_star_count_reg < nmeafc_pkg::HEX_DIGITS)
                        begin
                            if (!nmeafc_pkg::is_hex(c))
                            begin
                                hex_error_next = 1'b1;
                            end
                            else
                            begin
                                hex_value_next = {hex_value_reg[3:0],
                                                  nmeafc_pkg::hex_nibble(c)};
                            end
                        end
                    end
                end
                held_byte_next  = byte_in;
                held_valid_next = 1'b1;
            end
            else
            begin
                // end of sentence: report and go back to hunting
                report_valid     = 1'b1;
                in_sentence_next = 1'b0;
                clear_sentence   = 1'b1;
            end
        end

        if (clear_sentence)
        begin
            held_byte_next        = '0;
            held_valid_next       = 1'b0;
            running_xor_next      = '0;
            star_seen_next        = 1'b0;
            after_star_count_next = '0;
            hex_value_next        = '0;
            hex_error_next        = 1'b0;
            length_count_next     = '0;
            comma_count_next      = '0;
            first_field_done_next = 1'b0;
            first_field_len_next  = '0;
            for (int i = 0; i < 5; i++)
            begin
                id_chars_next[i] = '0;
            end
        end
    end

    // report contents from the collected state
    always_comb
    begin
        if (!star_seen_reg)
        begin
            report.status = nmeafc_pkg::ST_OK_NO_CHECKSUM;
        end
        else if (after_star_count_reg != nmeafc_pkg::HEX_DIGITS)
        begin
            report.status = nmeafc_pkg::ST_STAR_MISPLACED;
        end
        else if (hex_error_reg)
        begin
            report.status = nmeafc_pkg::ST_BAD_HEX;
        end
        else if (hex_value_reg == running_xor_reg)
        begin
            report.status = nmeafc_pkg::ST_MATCH;
        end
        else
        begin
            report.status = nmeafc_pkg::ST_MISMATCH;
        end

        report.computed_checksum = running_xor_reg;
        report.received_checksum =
            (report.status == nmeafc_pkg::ST_MATCH ||
             report.status == nmeafc_pkg::ST_MISMATCH) ? hex_value_reg : 8'd0;
        report.sentence_length = length_count_reg;
        report.field_count =
            (comma_count_reg == nmeafc_pkg::COMMA_MAX) ? nmeafc_pkg::COMMA_MAX
                                                       : comma_count_reg + 5'd1;
        report.id_length_ok = (first_field_len_reg == nmeafc_pkg::ID_LEN);

        // talker from the first two characters
        if (first_field_len_reg < nmeafc_pkg::TALKER_LEN)
        begin
            report.talker_code = nmeafc_pkg::TK_OTHER;
        end
        else if (id_chars_reg[0] == nmeafc_pkg::CH_G_UP &&
                 id_chars_reg[1] == nmeafc_pkg::CH_P_UP)
        begin
            report.talker_code = nmeafc_pkg::TK_GP;
        end
        else if (id_chars_reg[0] == nmeafc_pkg::CH_G_UP &&
                 id_chars_reg[1] == nmeafc_pkg::CH_L_UP)
        begin
            report.talker_code = nmeafc_pkg::TK_GL;
        end
        else if ((id_chars_reg[0] == nmeafc_pkg::CH_G_UP &&
                  id_chars_reg[1] == nmeafc_pkg::CH_B_UP) ||
                 (id_chars_reg[0] == nmeafc_pkg::CH_B_UP &&
                  id_chars_reg[1] == nmeafc_pkg::CH_D_UP))
        begin
            report.talker_code = nmeafc_pkg::TK_GB_BD;
        end
        else if (id_chars_reg[0] == nmeafc_pkg::CH_G_UP &&
                 id_chars_reg[1] == nmeafc_pkg::CH_A_UP)
        begin
            report.talker_code = nmeafc_pkg::TK_GA;
        end
        else
        begin
            report.talker_code = nmeafc_pkg::TK_OTHER;
        end

        // sentence type from characters three to five
        if (first_field_len_reg < nmeafc_pkg::ID_LEN)
        begin
            report.sentence_type = nmeafc_pkg::KIND_OTHER;
        end
        else if (id_chars_reg[2] == nmeafc_pkg::CH_G_UP &&
                 id_chars_reg[3] == nmeafc_pkg::CH_G_UP &&
                 id_chars_reg[4] == nmeafc_pkg::CH_A_UP)
        begin
            report.sentence_type = nmeafc_pkg::KIND_GGA;
        end
        else if (id_chars_reg[2] == nmeafc_pkg::CH_G_UP &&
                 id_chars_reg[3] == nmeafc_pkg::CH_S_UP &&
                 id_chars_reg[4] == nmeafc_pkg::CH_V_UP)
        begin
            report.sentence_type = nmeafc_pkg::KIND_GSV;
        end
        else
        begin
            report.sentence_type = nmeafc_pkg::KIND_OTHER;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg      <= 1'b0;
            held_byte_reg        <= '0;
            held_valid_reg       <= 1'b0;
            running_xor_reg      <= '0;
            star_seen_reg        <= 1'b0;
            after_star_count_reg <= '0;
            hex_value_reg        <= '0;
            hex_error_reg        <= 1'b0;
            length_count_reg     <= '0;
            comma_count_reg      <= '0;
            first_field_done_reg <= 1'b0;
            first_field_len_reg  <= '0;
            for (int i = 0; i < 5; i++)
            begin
                id_chars_reg[i] <= '0;
            end
        end
        else
        begin
            in_sentence_reg      <= in_sentence_next;
            held_byte_reg        <= held_byte_next;
            held_valid_reg       <= held_valid_next;
            running_xor_reg      <= running_xor_next;
            star_seen_reg        <= star_seen_next;
            after_star_count_reg <= after_star_count_next;
            hex_value_reg        <= hex_value_next;
            hex_error_reg        <= hex_error_next;
            length_count_reg     <= length_count_next;
            comma_count_reg      <= comma_count_next;
            first_field_done_reg <= first_field_done_next;
            first_field_len_reg  <= first_field_len_next;
            id_chars_reg         <= id_chars_next;
        end
    end

endmodule

`default_nettype wire

/* src/nmea_sentence_framer_checker_unit.sv */
// nmea 0183 sentence framer and checksum checker
//
// input channel: one received byte per beat on rx_byte (in_valid / in_stall).
// output channel: one report beat per sentence, on the LF that ends it
// (out_valid / out_stall); bytes that end no sentence give no beat.
// a sentence starts at '$'; the byte right before LF (normally CR) is dropped.
//
// order: a byte taken lands in the input register, and the report that it
// ends is loaded from there into the output register, which drives
// out_valid and the report outputs.
// throughput: one byte per cycle while the output register is not stalled.
//
// reset: the framer goes back to hunting for '$', both registers empty.
// receiver stall: the report waits in the output register; the input register
// still takes one more byte if it is empty, then in_stall rises until the
// report is taken.
`default_nettype none

module nmea_sentence_framer_checker_unit #(
    parameter int MAX_LENGTH = 127
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic [7:0]      computed_checksum,
    output logic [7:0]      received_checksum,
    output logic [6:0]      sentence_length,
    output logic [4:0]      field_count,
    output logic            id_length_ok,
    output logic [2:0]      talker_code,
    output logic [1:0]      sentence_type
);

    localparam int LEN_CAP = (MAX_LENGTH < 127) ? MAX_LENGTH : 127;

    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;
    logic                out_valid_reg;
    nmeafc_pkg::report_t out_report_reg;

    logic                advance;
    logic                step;
    logic                report_valid;
    nmeafc_pkg::report_t report;

    // pipeline moves when the output register is free or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // framing and checksum state
    nmeafc_core #(
        .LEN_CAP (LEN_CAP)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .byte_in      (s1_byte_reg),
        .report_valid (report_valid),
        .report       (report)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && report_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && report_valid)
        begin
            out_report_reg <= report;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_report_reg.status;
    assign computed_checksum = out_report_reg.computed_checksum;
    assign received_checksum = out_report_reg.received_checksum;
    assign sentence_length   = out_report_reg.sentence_length;
    assign field_count       = out_report_reg.field_count;
    assign id_length_ok      = out_report_reg.id_length_ok;
    assign talker_code       = out_report_reg.talker_code;
    assign sentence_type     = out_report_reg.sentence_type;

endmodule

`default_nettype wire

/* src/nmeafc_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module nmeafc_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [2:0] status,
    input  wire logic [7:0] computed_checksum,
    input  wire logic [7:0] received_checksum,
    input  wire logic [6:0] sentence_length,
    input  wire logic [4:0] field_count,
    input  wire logic [2:0] talker_code
);

    logic is_match;
    logic sum_checked;
    logic sums_equal;
    logic is_empty;
    logic empty_ok;

    // report decodes used by the properties
    assign is_match    = out_valid && status == nmeafc_pkg::ST_MATCH;
    assign sum_checked = status == nmeafc_pkg::ST_MATCH || status == nmeafc_pkg::ST_MISMATCH;
    assign sums_equal  = received_checksum == computed_checksum;
    assign is_empty    = out_valid && sentence_length == 7'd0;
    assign empty_ok    = field_count == 5'd1 && talker_code == nmeafc_pkg::TK_OTHER;

    // a stalled report beat stays up
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "report dropped")

    // a match really means the two checksums agree
    `ASSERT_IMPLIES(a_match_equal, clk, rst_n, is_match, sums_equal, "match, sums differ")

    // received checksum is zero unless both hex digits were checked
    `ASSERT_IMPLIES(a_rx_zero, clk, rst_n, out_valid && !sum_checked, received_checksum == 8'd0, "rx sum")

    // an empty sentence has one field and no talker
    `ASSERT_IMPLIES(a_empty, clk, rst_n, is_empty, empty_ok, "empty sentence inconsistent")

endmodule

bind nmea_sentence_framer_checker_unit nmeafc_checker u_nmeafc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .computed_checksum (computed_checksum),
    .received_checksum (received_checksum),
    .sentence_length   (sentence_length),
    .field_count       (field_count),
    .talker_code       (talker_code)
);

`default_nettype wire
